FILE: rtl/skbsc_pkg.sv
// Shared constants for the self-keyed byte stream cipher core.
// No dependencies; imported by the top-level module.
package skbsc_pkg;

  // Byte and configuration widths
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned KEY_BYTES_DEF = 16;
  localparam int unsigned KEY_BYTES_MAX = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

  // Substitute for a buffer entry that sums to zero
  localparam logic [BYTE_W-1:0] ZERO_SUBST = 8'd1;

endpackage

FILE: rtl/self_keyed_byte_stream_cipher_core.sv
// Top level of the self-keyed byte stream cipher: key registers, rotating
// work buffer, input stage and result register. Depends on skbsc_pkg.
//
//   channel | direction | ports                              | handshake
//   --------+-----------+------------------------------------+-------------------
//   in      | to core   | in_data_in, in_start_req           | in_valid/in_stall
//   out     | from core | out_data_out                       | out_valid/out_stall
//   cfg     | to core   | cfg_index, cfg_data                | cfg_we (no wait)
//
// One byte per cycle is sustained while the result is not stalled; a request
// is registered in the input stage, where the keystream and the buffer update
// are computed, and then in the result register.
// Reset is synchronous and active low; it clears the key, the buffer and the
// position. A stalled result holds the result register; the input stage keeps
// taking requests until it is full as well.
module self_keyed_byte_stream_cipher_core
  import skbsc_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_data_in,
  input  logic                  in_start_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_data_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned POS_W  = $clog2(KEY_BYTES);
  localparam int unsigned PROD_W = BYTE_W + POS_W;

  // Configuration registers
  logic [CFG_DATA_W-1:0] key_low_r, key_high_r;
  logic [2*CFG_DATA_W-1:0] key_cat;

  // Buffer state: ring_r[k] holds work_buf[(pos + k) mod KEY_BYTES]
  logic [BYTE_W-1:0] ring_r   [KEY_BYTES];
  logic [BYTE_W-1:0] ring_eff [KEY_BYTES];
  logic [BYTE_W-1:0] ring_nxt [KEY_BYTES];
  logic [BYTE_W-1:0] b0_r, b0_eff, b0_nxt;
  logic [POS_W-1:0]  pos_r, pos_eff, pos_nxt;

  // Input stage and result register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_start_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r;

  logic              in_acc, adv;
  logic [PROD_W-1:0] prod;
  logic [BYTE_W-1:0] ks;
  logic [BYTE_W:0]   sum_full;
  logic [BYTE_W-1:0] sum;

  // Handshake: the input stage moves on when the result register is free
  assign adv          = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !adv;
  assign in_acc       = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  assign key_cat = {key_high_r, key_low_r};

  // A start mark reloads the buffer from the key before the byte is used
  always_comb begin
    for (int k = 0; k < KEY_BYTES; k++) begin
      ring_eff[k] = s1_start_r ? key_cat[BYTE_W*k +: BYTE_W] : ring_r[k];
    end
    b0_eff  = s1_start_r ? key_cat[BYTE_W-1:0] : b0_r;
    pos_eff = s1_start_r ? '0 : pos_r;
  end

  // Keystream byte and new value of the current entry
  always_comb begin
    prod     = PROD_W'(b0_eff) * PROD_W'(pos_eff);
    ks       = ring_eff[0] ^ prod[BYTE_W-1:0];
    sum_full = {1'b0, ring_eff[0]} + {1'b0, ring_eff[1]};
    sum      = (sum_full[BYTE_W-1:0] == '0) ? ZERO_SUBST : sum_full[BYTE_W-1:0];
  end

  // Rotate the ring by one; the updated entry goes to the tail
  always_comb begin
    for (int k = 0; k < KEY_BYTES - 1; k++) begin
      ring_nxt[k] = ring_eff[k+1];
    end
    ring_nxt[KEY_BYTES-1] = sum;
    b0_nxt  = (pos_eff == '0) ? sum : b0_eff;
    pos_nxt = (pos_eff == POS_W'(KEY_BYTES - 1)) ? '0 : pos_eff + 1'b1;
  end

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Buffer, reference byte and position advance with each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_BYTES; k++) begin
        ring_r[k] <= '0;
      end
      b0_r  <= '0;
      pos_r <= '0;
    end else if (adv) begin
      for (int k = 0; k < KEY_BYTES; k++) begin
        ring_r[k] <= ring_nxt[k];
      end
      b0_r  <= b0_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r  <= in_data_in;
      s1_start_r <= in_start_req;
    end
    if (adv) begin
      out_data_r <= s1_data_r ^ ks;
    end
  end

`ifndef SYNTHESIS
  // The position never leaves the key length.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(KEY_BYTES - 1))
    else $error("position out of range");

  // At position zero the ring head and the reference copy agree.
  a_b0_track: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> (ring_r[0] == b0_r))
    else $error("reference byte lost track of buffer entry zero");

  // A processed start request leaves the position at one.
  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_start_r) |=> (pos_r == POS_W'(1)))
    else $error("start request did not restart the position");

  // A request that leaves the input stage lands in the result register.
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("request lost between stages");
`endif

endmodule

FILE: sim/self_keyed_byte_stream_cipher_core_test.sv
// Self-checking testbench for the self-keyed byte stream cipher core: directed bytes,
// then random messages under random stalls, checked against a byte-level keystream model.
// Depends on skbsc_pkg and self_keyed_byte_stream_cipher_core.
module self_keyed_byte_stream_cipher_core_test;
  import skbsc_pkg::*;

  localparam int unsigned NUM_KEY_BYTES = KEY_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1450;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // Keystream predictor and store of expected output bytes.
  class keystream_scoreboard;
    logic [CFG_DATA_W-1:0] key_lo;
    logic [CFG_DATA_W-1:0] key_hi;
    logic [BYTE_W-1:0]     work[KEY_BYTES_MAX];
    int unsigned           pos;
    logic [BYTE_W-1:0]     expected_bytes[$];
    int unsigned           errors;
    int unsigned           checked;

    function new();
      key_lo = '0;
      key_hi = '0;
      foreach (work[i]) work[i] = '0;
      pos = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void load_key(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_KEY_LOW) key_lo = value;
      else key_hi = value;
    endfunction

    function logic [BYTE_W-1:0] key_byte(int unsigned k);
      if (k < 8) return key_lo[8*k +: 8];
      return key_hi[8*(k-8) +: 8];
    endfunction

    // Work out the output byte for one accepted request and advance the buffer.
    function void note_request(logic [BYTE_W-1:0] data, logic start);
      int unsigned p;
      int unsigned nx;
      logic [31:0] prod;
      logic [BYTE_W-1:0] ks;
      logic [BYTE_W-1:0] sum;
      if (start) begin
        for (int i = 0; i < KEY_BYTES_MAX; i++)
          work[i] = (i < NUM_KEY_BYTES) ? key_byte(i) : '0;
        pos = 0;
      end
      p = (pos >= NUM_KEY_BYTES) ? 0 : pos;
      prod = work[0] * p;
      ks = work[p] ^ prod[BYTE_W-1:0];
      expected_bytes.push_back(data ^ ks);
      nx = (p < NUM_KEY_BYTES - 1) ? p + 1 : 0;
      sum = work[p] + work[nx];
      if (sum == '0) sum = ZERO_SUBST;
      work[p] = sum;
      p++;
      pos = (p >= NUM_KEY_BYTES) ? 0 : p;
    endfunction

    // Compare one accepted output byte with the oldest expectation.
    function void check_result(logic [BYTE_W-1:0] actual);
      logic [BYTE_W-1:0] exp_byte;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output byte, expected none, actual %h", $time, actual);
        errors++;
        return;
      end
      exp_byte = expected_bytes.pop_front();
      checked++;
      if (actual !== exp_byte) begin
        $display("%0t: data_out mismatch, expected %h, actual %h", $time, exp_byte, actual);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // Anything still waiting at the end is a missing result.
    function void check_empty();
      while (expected_bytes.size() != 0) begin
        $display("%0t: missing output byte, expected %h, actual none",
                 $time, expected_bytes.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_in;
  logic                  in_start_req;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_data_out;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  keystream_scoreboard sb;
  int unsigned tx_max;
  int unsigned rx_max;
  bit          hold_req;
  int unsigned holds_done;
  int unsigned bytes_sent;
  int unsigned key_writes;
  int unsigned messages_sent;
  int unsigned cycle_count;

  self_keyed_byte_stream_cipher_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_in   (in_data_in),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Both channels are observed at the rising edge; requests are noted before results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data_in, in_start_req);
      if (out_valid && !out_stall) sb.check_result(out_data_out);
    end
  end

  // Result side: random stalls per result, and a long hold-off when requested.
  initial begin : result_sink
    int unsigned w;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      w = $urandom_range(0, rx_max);
      repeat (w) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Offer one request after a random gap and wait until it is taken.
  // Entered and left at a falling edge; valid stays high for a back-to-back request.
  task automatic send_byte(logic [BYTE_W-1:0] data, logic start);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_in   <= data;
    in_start_req <= start;
    do @(posedge clk); while (!(in_valid && !in_stall));
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one key register; only called while the core is idle.
  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.load_key(idx, value);
    key_writes++;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_key(int unsigned phase);
    logic [CFG_DATA_W-1:0] v;
    v = {$urandom, $urandom};
    if (phase == 0) return '1;
    if (phase == 1) return '0;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {8{8'h80}};
      3: return v & {8{8'h0F}};
      default: return v;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_end;
    int unsigned len;
    int unsigned total_goal;
    sb = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_in   = '0;
    in_start_req = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_KEY_LOW;
    cfg_data     = '0;
    tx_max       = 0;
    rx_max       = 0;
    hold_req     = 1'b0;
    holds_done   = 0;
    bytes_sent   = 0;
    key_writes   = 0;
    messages_sent = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bytes with no start mark after reset run on the all-zero buffer.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    drain();

    // Key bytes 0xFF followed by 0x01 make a buffer sum wrap to zero.
    write_key(CFG_KEY_LOW, '1);
    write_key(CFG_KEY_HIGH, {8{8'h01}});
    for (int i = 0; i < 14; i++) begin
      if (i == 0) send_byte(8'h00, 1'b1);
      else if (i == 1) send_byte(8'hFF, 1'b0);
      else send_byte(8'($urandom), 1'b0);
    end
    drain();

    // A key change mid-message waits for the next start mark; the position wraps here.
    write_key(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    // Start mark in the middle of a message.
    send_byte(8'h5A, 1'b1);
    send_byte(8'hFF, 1'b0);
    drain();

    // Random phases: new keys and idling per phase, mostly well-formed messages.
    total_goal = bytes_sent + RANDOM_ITEMS;
    phase = 0;
    while (bytes_sent < total_goal) begin
      drain();
      write_key(CFG_KEY_LOW, pick_key(phase));
      write_key(CFG_KEY_HIGH, pick_key(phase));
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      if (phase == 2) begin
        // Receiver holds off while the sender keeps offering back to back.
        tx_max = 0;
        hold_req = 1'b1;
      end
      phase_end = bytes_sent + $urandom_range(100, 200);
      while (bytes_sent < phase_end && bytes_sent < total_goal) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: loose bytes with random start marks.
          len = $urandom_range(1, 5);
          for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'($urandom));
        end else begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
          messages_sent++;
          for (int i = 0; i < len; i++) begin
            if (i == 0) send_byte(8'($urandom), 1'b1);
            else send_byte(8'($urandom), ($urandom_range(0, 29) == 0));
          end
        end
      end
      phase++;
    end

    drain();
    sb.check_empty();
    $display("Sent %0d bytes in %0d messages over %0d phases; %0d results checked.",
             bytes_sent, messages_sent, phase, sb.checked);
    $display("Made %0d key writes and %0d long receiver hold-offs.", key_writes, holds_done);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/skbsc_pkg.sv
rtl/self_keyed_byte_stream_cipher_core.sv
sim/self_keyed_byte_stream_cipher_core_test.sv
